/* hdl/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg - shared types and constants for the command frame parser
// Beat payload structs, header and control codes, CRC-16/Modbus byte update.
// ----------------------------------------------------------------------------
package cfp_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       txt_on;
    logic       csv_on;
    logic       print_on;
    logic       crc_good;
    logic       stopped_txt;
    logic       stopped_csv;
    logic       write_txt;
    logic       write_csv;
    logic       print_record;
    logic       first_print;
  } out_item_t;

  // header bytes, oldest first
  localparam logic [7:0] HDR_B0 = 8'h88;
  localparam logic [7:0] HDR_B1 = 8'h67;
  localparam logic [7:0] HDR_B2 = 8'h96;

  // control codes, high byte first on the wire
  localparam logic [15:0] CODE_TXT_START = 16'h9BB7;
  localparam logic [15:0] CODE_CSV_START = 16'h9BB8;
  localparam logic [15:0] CODE_STOP      = 16'h5BB4;
  localparam logic [15:0] CODE_PRINT_ON  = 16'h3BB3;
  localparam logic [15:0] CODE_PRINT_OFF = 16'h3BB4;
  localparam logic [15:0] CODE_LAST_LINE = 16'h4BB1;
  localparam logic [15:0] CODE_RECORD    = 16'h4BB2;

  // event codes
  localparam logic [2:0] EV_TXT_START = 3'd0;
  localparam logic [2:0] EV_CSV_START = 3'd1;
  localparam logic [2:0] EV_STOP      = 3'd2;
  localparam logic [2:0] EV_PRINT_ON  = 3'd3;
  localparam logic [2:0] EV_PRINT_OFF = 3'd4;
  localparam logic [2:0] EV_LAST_LINE = 3'd5;
  localparam logic [2:0] EV_RECORD    = 3'd6;

  // position of the CRC low byte within each frame
  localparam logic [5:0] LONG_CRC_AT  = 6'd39;
  localparam logic [5:0] SHORT_CRC_AT = 6'd31;
  localparam logic [5:0] HDR_LEN      = 6'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // reflected CRC-16/Modbus, one byte
  function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC over 88 67 96 4B: the fixed part of both record headers
  localparam logic [15:0] CRC_HDR =
    crc16_upd(crc16_upd(crc16_upd(crc16_upd(CRC_INIT, HDR_B0), HDR_B1), HDR_B2), 8'h4B);

endpackage

/* hdl/cfp_in_stage.sv */
// ----------------------------------------------------------------------------
// cfp_in_stage - input register
// Holds one accepted beat until the parser consumes it.
// ----------------------------------------------------------------------------
module cfp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfp_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              hold_valid,
  output cfp_pkg::in_item_t hold_data
);
  import cfp_pkg::*;

  logic     valid_r;
  in_item_t data_r;

  assign in_ready   = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

/* hdl/cfp_parse.sv */
// ----------------------------------------------------------------------------
// cfp_parse - header scan, frame tracking and CRC check
// Holds all parser state; one byte per step, result formed combinationally.
// ----------------------------------------------------------------------------
module cfp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  cfp_pkg::in_item_t  item,
  output logic               has_res,
  output cfp_pkg::out_item_t res
);
  import cfp_pkg::*;

  typedef enum logic [1:0] {
    KIND_SCAN  = 2'd0,
    KIND_LONG  = 2'd1,
    KIND_SHORT = 2'd2
  } kind_t;

  logic [31:0] window_r, window_nxt;
  logic [2:0]  fill_r, fill_nxt;
  kind_t       kind_r, kind_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_low_r, crc_low_nxt;
  logic        txt_r, txt_nxt;
  logic        csv_r, csv_nxt;
  logic        prn_r, prn_nxt;
  logic [7:0]  pcount_r, pcount_nxt;

  logic [7:0]  b;
  logic [15:0] code;
  logic [15:0] rx_crc;
  logic [15:0] crc_step;
  logic        good;
  logic [5:0]  crc_at;
  logic        hdr_hit;
  logic        matched;

  always_comb begin
    b           = item.rx_byte;
    code        = {window_r[7:0], b};
    rx_crc      = {b, crc_low_r};
    crc_step    = crc16_upd(crc_r, b);
    good        = (rx_crc == crc_r);
    crc_at      = (kind_r == KIND_LONG) ? LONG_CRC_AT : SHORT_CRC_AT;
    hdr_hit     = (fill_r >= 3'd4) && (window_r[31:8] == {HDR_B0, HDR_B1, HDR_B2});
    matched     = 1'b0;
    has_res     = 1'b0;
    res         = '0;
    window_nxt  = window_r;
    fill_nxt    = fill_r;
    kind_nxt    = kind_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    crc_low_nxt = crc_low_r;
    txt_nxt     = txt_r;
    csv_nxt     = csv_r;
    prn_nxt     = prn_r;
    pcount_nxt  = pcount_r;

    case (kind_r)
      KIND_LONG, KIND_SHORT: begin
        if (cnt_r < crc_at) begin
          crc_nxt = crc_step;
          cnt_nxt = cnt_r + 6'd1;
        end else if (cnt_r == crc_at) begin
          crc_low_nxt = b;
          cnt_nxt     = cnt_r + 6'd1;
        end else begin
          has_res      = 1'b1;
          res.crc_good = good;
          if (kind_r == KIND_LONG) begin
            res.event_res = EV_LAST_LINE;
            res.write_txt = good && txt_r;
            res.write_csv = good && csv_r;
          end else begin
            res.event_res = EV_RECORD;
            if (good && prn_r) begin
              pcount_nxt       = pcount_r + 8'd1;
              res.print_record = 1'b1;
            end
            res.first_print = (pcount_nxt == 8'd1);
          end
          kind_nxt   = KIND_SCAN;
          cnt_nxt    = '0;
          crc_nxt    = CRC_INIT;
          window_nxt = '0;
          fill_nxt   = '0;
        end
      end
      default: begin
        if (hdr_hit) begin
          case (code)
            CODE_TXT_START: begin
              txt_nxt = 1'b1;
              has_res = 1'b1;
              res.event_res = EV_TXT_START;
            end
            CODE_CSV_START: begin
              csv_nxt = 1'b1;
              has_res = 1'b1;
              res.event_res = EV_CSV_START;
            end
            CODE_STOP: begin
              res.stopped_txt = txt_r;
              res.stopped_csv = csv_r;
              txt_nxt = 1'b0;
              csv_nxt = 1'b0;
              has_res = 1'b1;
              res.event_res = EV_STOP;
            end
            CODE_PRINT_ON: begin
              prn_nxt = 1'b1;
              has_res = 1'b1;
              res.event_res = EV_PRINT_ON;
            end
            CODE_PRINT_OFF: begin
              prn_nxt = 1'b0;
              has_res = 1'b1;
              res.event_res = EV_PRINT_OFF;
            end
            CODE_LAST_LINE, CODE_RECORD: begin
              // both codes share the high byte, so the header CRC is fixed
              crc_nxt  = crc16_upd(CRC_HDR, b);
              cnt_nxt  = HDR_LEN;
              kind_nxt = (code == CODE_LAST_LINE) ? KIND_LONG : KIND_SHORT;
              matched  = 1'b1;
            end
            default: ;
          endcase
        end
        if (matched || has_res) begin
          window_nxt = '0;
          fill_nxt   = '0;
        end else begin
          window_nxt = {window_r[23:0], b};
          if (fill_r < 3'd4) begin
            fill_nxt = fill_r + 3'd1;
          end
        end
      end
    endcase

    res.txt_on   = txt_nxt;
    res.csv_on   = csv_nxt;
    res.print_on = prn_nxt;

    // partial header or frame is dropped at the buffer boundary
    if (item.end_of_buffer) begin
      window_nxt = '0;
      fill_nxt   = '0;
      kind_nxt   = KIND_SCAN;
      cnt_nxt    = '0;
      crc_nxt    = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      fill_r    <= '0;
      kind_r    <= KIND_SCAN;
      cnt_r     <= '0;
      crc_r     <= CRC_INIT;
      crc_low_r <= '0;
      txt_r     <= 1'b0;
      csv_r     <= 1'b0;
      prn_r     <= 1'b0;
      pcount_r  <= '0;
    end else if (step) begin
      window_r  <= window_nxt;
      fill_r    <= fill_nxt;
      kind_r    <= kind_nxt;
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
      crc_low_r <= crc_low_nxt;
      txt_r     <= txt_nxt;
      csv_r     <= csv_nxt;
      prn_r     <= prn_nxt;
      pcount_r  <= pcount_nxt;
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'd4)
    else $error("window fill beyond four bytes");

  a_scan_clean: assert property (@(posedge clk) disable iff (!rst_n)
    kind_r == KIND_SCAN |-> cnt_r == 6'd0 && crc_r == CRC_INIT)
    else $error("frame count or CRC left over while scanning");

  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == KIND_LONG |-> cnt_r <= LONG_CRC_AT + 6'd1) and
    (kind_r == KIND_SHORT |-> cnt_r <= SHORT_CRC_AT + 6'd1))
    else $error("frame byte count overran the frame");

  a_eob_flush: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.end_of_buffer |=> kind_r == KIND_SCAN && fill_r == 3'd0)
    else $error("buffer end did not flush the parser");

endmodule

/* hdl/cfp_out_stage.sv */
// ----------------------------------------------------------------------------
// cfp_out_stage - result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module cfp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  cfp_pkg::out_item_t load_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cfp_pkg::out_item_t out_data
);
  import cfp_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

/* hdl/command_frame_parser_crc16.sv */
// Path: the byte completing a frame is held in the input register, and its result beat
//   is then loaded into the result register and offered from there.
// Throughput: one byte per cycle; the parser step is a single CRC byte update.
// A byte is held back only while a finished result waits in a full result register.
// Reset (rst_n low, synchronous): parser back to scanning, CRC to FFFF, all flags
//   and the print counter cleared, both registers empty.
// ----------------------------------------------------------------------------
// command_frame_parser_crc16 - command and record frame parser, top level
// Scans received bytes for 88 67 96 headers, tracks the logging and printing
// flags and checks record frames with CRC-16/Modbus.
// ----------------------------------------------------------------------------
module command_frame_parser_crc16 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cfp_pkg::out_item_t out_data
);
  import cfp_pkg::*;

  // held input beat
  logic      hold_valid;
  in_item_t  hold_data;

  // parser outputs
  logic      has_res;
  out_item_t res;

  // the held byte moves on when it yields no result, or the result slot
  // is empty or being drained in this cycle
  logic      advance;

  assign advance = hold_valid && (!has_res || !out_valid || out_ready);

  cfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  // parser state only steps on an advancing beat
  cfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (hold_data),
    .has_res (has_res),
    .res     (res)
  );

  // completed frames and commands land here
  cfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && has_res),
    .load_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/tb_command_frame_parser_crc16.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_frame_parser_crc16 - self-checking bench for the frame parser
// Drives byte beats through valid/ready, predicts every command and record
// report with a local parser model and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_command_frame_parser_crc16;
  import cfp_pkg::*;

  // parser position, as tracked by the local model
  typedef enum logic [1:0] {SCANNING, IN_LONG, IN_SHORT} frame_kind_t;
  // how the payload of a generated record frame is filled
  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_HEADERS} fill_t;

  localparam int HOLD_CYCLES = 300;  // long receiver hold-off
  localparam int DRAIN_LIMIT = 20000; // cycles allowed for the last results
  localparam int TAIL_CYCLES = 8;     // idle clocks after the drain, before the verdict

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;

  // idle rates in percent, per side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long hold-off request; the receiver process counts it down itself
  logic hold_req = 1'b0;
  int   hold_ctr = 0;

  int mismatches = 0;

  // expected report beats, oldest first
  out_item_t frame_reports_due[$];

  // parser model state
  logic [31:0] scan_win = '0;   // last four scanned bytes, newest low
  logic [2:0]  scan_fill = '0;
  frame_kind_t kind = SCANNING;
  logic [5:0]  frame_pos = '0;
  logic [15:0] crc_run = CRC_INIT;
  logic [7:0]  crc_lo_rx = '0;
  logic        txt_log = 1'b0;
  logic        csv_log = 1'b0;
  logic        print_en = 1'b0;
  logic [7:0]  print_cnt = '0;

  logic [15:0] command_codes [5] = '{CODE_TXT_START, CODE_CSV_START, CODE_STOP,
                                     CODE_PRINT_ON, CODE_PRINT_OFF};

  command_frame_parser_crc16 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Modbus CRC, reflected polynomial A001, one byte at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    repeat (8) begin
      if (acc[0]) acc = (acc >> 1) ^ 16'hA001;
      else        acc = acc >> 1;
    end
    return acc;
  endfunction

  function automatic string describe_report(input out_item_t r);
    return $sformatf({"ev=%0d txt=%b csv=%b prn=%b crc_ok=%b stop_txt=%b stop_csv=%b ",
                      "wr_txt=%b wr_csv=%b print=%b first=%b"},
                     r.event_res, r.txt_on, r.csv_on, r.print_on, r.crc_good,
                     r.stopped_txt, r.stopped_csv, r.write_txt, r.write_csv,
                     r.print_record, r.first_print);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Advance the parser model by one accepted byte; queue a report if a frame
  // completes on it.
  task automatic parse_byte(input logic [7:0] b, input logic eob);
    out_item_t   rep;
    logic        done;
    logic        claimed;
    logic        good;
    logic [5:0]  crc_at;
    logic [15:0] code;
    logic [15:0] acc;
    rep = '0;
    done = 1'b0;
    claimed = 1'b0;
    if (kind == IN_LONG || kind == IN_SHORT) begin
      // inside a record: no header scanning at all
      crc_at = (kind == IN_LONG) ? LONG_CRC_AT : SHORT_CRC_AT;
      if (frame_pos < crc_at) begin
        crc_run = crc_byte(crc_run, b);
        frame_pos++;
      end else if (frame_pos == crc_at) begin
        crc_lo_rx = b;
        frame_pos++;
      end else begin
        // CRC travels low byte first
        good = ({b, crc_lo_rx} == crc_run);
        rep.crc_good = good;
        if (kind == IN_LONG) begin
          rep.event_res = EV_LAST_LINE;
          rep.write_txt = good & txt_log;
          rep.write_csv = good & csv_log;
        end else begin
          rep.event_res = EV_RECORD;
          if (good && print_en) begin
            print_cnt++;
            rep.print_record = 1'b1;
          end
          rep.first_print = (print_cnt == 8'd1);
        end
        done = 1'b1;
        kind = SCANNING;
        frame_pos = '0;
        crc_run = CRC_INIT;
        scan_win = '0;
        scan_fill = '0;
      end
    end else begin
      if (scan_fill >= 3'd4 && scan_win[31:8] == {HDR_B0, HDR_B1, HDR_B2}) begin
        code = {scan_win[7:0], b};
        case (code)
          CODE_TXT_START: begin
            txt_log = 1'b1;
            rep.event_res = EV_TXT_START;
            done = 1'b1;
          end
          CODE_CSV_START: begin
            csv_log = 1'b1;
            rep.event_res = EV_CSV_START;
            done = 1'b1;
          end
          CODE_STOP: begin
            rep.stopped_txt = txt_log;
            rep.stopped_csv = csv_log;
            txt_log = 1'b0;
            csv_log = 1'b0;
            rep.event_res = EV_STOP;
            done = 1'b1;
          end
          CODE_PRINT_ON: begin
            print_en = 1'b1;
            rep.event_res = EV_PRINT_ON;
            done = 1'b1;
          end
          CODE_PRINT_OFF: begin
            print_en = 1'b0;
            rep.event_res = EV_PRINT_OFF;
            done = 1'b1;
          end
          CODE_LAST_LINE, CODE_RECORD: begin
            // header bytes are part of the CRC
            acc = CRC_INIT;
            for (int k = 3; k >= 0; k--) acc = crc_byte(acc, scan_win[8*k +: 8]);
            crc_run = crc_byte(acc, b);
            frame_pos = HDR_LEN;
            kind = (code == CODE_LAST_LINE) ? IN_LONG : IN_SHORT;
            claimed = 1'b1;
          end
          default: ;  // unknown code: keep scanning byte by byte
        endcase
        claimed = claimed | done;
      end
      if (claimed) begin
        scan_win = '0;
        scan_fill = '0;
      end else begin
        scan_win = {scan_win[23:0], b};
        if (scan_fill < 3'd4) scan_fill++;
      end
    end
    // end of buffer drops whatever is partial
    if (eob) begin
      scan_win = '0;
      scan_fill = '0;
      kind = SCANNING;
      frame_pos = '0;
      crc_run = CRC_INIT;
    end
    if (done) begin
      rep.txt_on = txt_log;
      rep.csv_on = csv_log;
      rep.print_on = print_en;
      frame_reports_due.push_back(rep);
    end
  endtask

  // One byte beat: optional idle gap, then valid held until ready.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{rx_byte: b, end_of_buffer: eob};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(b, eob);
  endtask

  task automatic send_run(input logic [7:0] seq[$], input bit eob_last);
    foreach (seq[i]) send_byte(seq[i], eob_last && (i == seq.size() - 1));
  endtask

  // Header, code and, for records, payload and CRC. keep > 0 cuts the frame
  // to that many bytes; eob_last flags the last byte sent.
  task automatic send_frame(input logic [15:0] code, input bit corrupt, input fill_t fill,
                            input int keep, input bit eob_last);
    logic [7:0]  fb[$];
    logic [15:0] acc;
    int          span;
    fb = {HDR_B0, HDR_B1, HDR_B2, code[15:8], code[7:0]};
    if (code == CODE_LAST_LINE || code == CODE_RECORD) begin
      span = (code == CODE_LAST_LINE) ? int'(LONG_CRC_AT) : int'(SHORT_CRC_AT);
      while (fb.size() < span) begin
        case (fill)
          FILL_ZERO: fb.push_back(8'h00);
          FILL_HEADERS: begin
            // a txt start command buried in the payload must not be seen
            case (fb.size() % 5)
              0:       fb.push_back(HDR_B0);
              1:       fb.push_back(HDR_B1);
              2:       fb.push_back(HDR_B2);
              3:       fb.push_back(CODE_TXT_START[15:8]);
              default: fb.push_back(CODE_TXT_START[7:0]);
            endcase
          end
          default: fb.push_back(8'($urandom));
        endcase
      end
      acc = CRC_INIT;
      foreach (fb[i]) acc = crc_byte(acc, fb[i]);
      if (corrupt) acc ^= 16'(1 << $urandom_range(15));
      fb.push_back(acc[7:0]);
      fb.push_back(acc[15:8]);
    end
    if (keep > 0) while (fb.size() > keep) void'(fb.pop_back());
    send_run(fb, eob_last);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_ctr = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_ctr > 0) begin
      hold_ctr--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: every accepted beat against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_reports_due.size() == 0) begin
        note_mismatch({"unexpected result: ", describe_report(out_data)});
      end else begin
        want = frame_reports_due.pop_front();
        if (out_data !== want)
          note_mismatch($sformatf("exp %s | got %s", describe_report(want),
                                  describe_report(out_data)));
      end
    end
  end

  // Every command, stop with nothing running, unknown code with rescan,
  // extreme byte values as noise.
  task automatic test_commands();
    send_idle_pct = 26;
    recv_idle_pct = 60;
    send_frame(CODE_STOP, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_run({8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b0);
    send_frame(CODE_TXT_START, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_CSV_START, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_STOP, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_PRINT_ON, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_PRINT_OFF, 1'b0, FILL_RANDOM, 0, 1'b0);
    // 88 67 96 then 88 67 is an unknown code; the rescan finds the later header
    send_run({HDR_B0, HDR_B1, HDR_B2, HDR_B0, HDR_B1, HDR_B2,
              CODE_TXT_START[15:8], CODE_TXT_START[7:0]}, 1'b0);
    send_frame(CODE_STOP, 1'b0, FILL_RANDOM, 0, 1'b0);
  endtask

  // Both record lengths, good and bad CRC, zero payload, buried headers.
  task automatic test_record_frames();
    send_idle_pct = 60;
    recv_idle_pct = 26;
    send_frame(CODE_TXT_START, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_CSV_START, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_PRINT_ON, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_LAST_LINE, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_LAST_LINE, 1'b1, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_RECORD, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_RECORD, 1'b0, FILL_ZERO, 0, 1'b0);
    send_frame(CODE_RECORD, 1'b1, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_LAST_LINE, 1'b0, FILL_HEADERS, 0, 1'b0);
    send_frame(CODE_STOP, 1'b0, FILL_RANDOM, 0, 1'b0);
    send_frame(CODE_LAST_LINE, 1'b0, FILL_ZERO, 0, 1'b0);
  endtask

  // Frames cut at end of buffer, frames that finish on the flagged byte,
  // and a header split across two buffers.
  task automatic test_buffer_edges();
    send_idle_pct = 26;
    recv_idle_pct = 60;
    send_frame(CODE_LAST_LINE, 1'b0, FILL_RANDOM, 20, 1'b1);
    send_frame(CODE_PRINT_ON, 1'b0, FILL_RANDOM, 0, 1'b1);
    send_frame(CODE_RECORD, 1'b0, FILL_RANDOM, 0, 1'b1);
    send_frame(CODE_RECORD, 1'b0, FILL_RANDOM, 32, 1'b1);
    send_frame(CODE_TXT_START, 1'b0, FILL_RANDOM, 3, 1'b1);
    send_run({CODE_TXT_START[15:8], CODE_TXT_START[7:0]}, 1'b0);
    send_frame(CODE_CSV_START, 1'b0, FILL_RANDOM, 4, 1'b1);
    send_frame(CODE_PRINT_OFF, 1'b0, FILL_RANDOM, 0, 1'b0);
  endtask

  // Receiver holds off for a long stretch while commands keep coming, so the
  // result register fills and input beats are held back.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (20) send_frame(command_codes[$urandom_range(4)], 1'b0, FILL_RANDOM, 0, 1'b0);
  endtask

  // A few good records while printing; the print counter steps on each.
  task automatic test_print_count();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_frame(CODE_PRINT_ON, 1'b0, FILL_RANDOM, 0, 1'b0);
    repeat (4) send_frame(CODE_RECORD, 1'b0, FILL_RANDOM, 0, 1'b0);
  endtask

  // Mostly well-formed frames with random content; the rest unknown codes,
  // cut frames and noise.
  task automatic test_random_stream(input int send_pct, input int recv_pct, input int beats);
    int sent;
    int pick;
    int len;
    logic [15:0] code;
    logic [7:0] junk[$];
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_frame(command_codes[$urandom_range(4)], 1'b0, FILL_RANDOM, 0,
                   ($urandom_range(5) == 0));
        len = 5;
      end else if (pick < 70) begin
        code = (pick < 50) ? CODE_LAST_LINE : CODE_RECORD;
        send_frame(code, ($urandom_range(3) == 0), fill_t'($urandom_range(2)), 0,
                   ($urandom_range(5) == 0));
        len = (code == CODE_LAST_LINE) ? 41 : 33;
      end else if (pick < 77) begin
        // unknown code, or a known one by chance
        send_frame(16'($urandom), 1'b0, FILL_RANDOM, 5, ($urandom_range(3) == 0));
        len = 5;
      end else if (pick < 85) begin
        code = ($urandom_range(1) == 1) ? CODE_LAST_LINE : CODE_RECORD;
        len = $urandom_range((code == CODE_LAST_LINE) ? 40 : 32, 1);
        send_frame(code, 1'b0, FILL_RANDOM, len, 1'b1);
      end else begin
        junk = {};
        len = $urandom_range(8, 1);
        repeat (len) begin
          // bias towards header bytes so partial headers turn up
          if ($urandom_range(2) == 0) junk.push_back(HDR_B0 + 8'($urandom_range(2) * 8'h0E));
          else                        junk.push_back(8'($urandom));
        end
        send_run(junk, ($urandom_range(2) == 0));
      end
      sent += len;
    end
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_commands();
    test_record_frames();
    test_buffer_edges();
    test_backpressure();
    test_print_count();
    test_random_stream(26, 60, 350);
    test_random_stream(60, 26, 350);
    test_random_stream(0, 0, 350);

    @(negedge clk);
    in_valid <= 1'b0;

    waited = 0;
    while (frame_reports_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    foreach (frame_reports_due[i])
      note_mismatch({"missing result: ", describe_report(frame_reports_due[i])});
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
